[hdl/sparse_compact_index_map_macros.svh]
// Assertion helpers for the RTL of the index map.
`ifndef SPARSE_COMPACT_INDEX_MAP_MACROS_SVH
`define SPARSE_COMPACT_INDEX_MAP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCIM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sparse_compact_index_map: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SCIM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sparse_compact_index_map: next-cycle check failed");

`endif

[hdl/scim_pkg.sv]
`timescale 1ns / 1ps

package scim_pkg;

    localparam int IDX_W  = 10;
    localparam int RES_W  = 11;
    localparam int SIZE_W = 11;

    typedef logic [2:0] t_op;

    localparam t_op OP_INIT  = 3'd0;
    localparam t_op OP_SET   = 3'd1;
    localparam t_op OP_SETUP = 3'd2;
    localparam t_op OP_MAP   = 3'd3;
    localparam t_op OP_REV   = 3'd4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
    localparam logic [SIZE_W-1:0] MISS_LIMIT = 11'd1024;

endpackage

[hdl/scim_if.sv]
`timescale 1ns / 1ps

interface scim_cmd_if;
    import scim_pkg::*;

    logic             valid;
    logic             ready;
    t_op              operation;
    logic [IDX_W-1:0] index;
    logic             mapped;
    logic             first_of_list;

    modport source (output valid, operation, index, mapped, first_of_list, input ready);
    modport sink   (input valid, operation, index, mapped, first_of_list, output ready);
endinterface

interface scim_res_if;
    import scim_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [RES_W-1:0]  result_index;
    logic                     found;
    logic                     emitted;
    logic [SIZE_W-1:0]        missed_count;
    logic [SIZE_W-1:0]        compact_count;

    modport source (output valid, result_index, found, emitted, missed_count, compact_count,
                    input ready);
    modport sink   (input valid, result_index, found, emitted, missed_count, compact_count,
                    output ready);
endinterface

[hdl/scim_ram.sv]
`timescale 1ns / 1ps

module scim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/sparse_compact_index_map.sv]
// Set, map feature, compact-to-sparse and unused codes: an accepted command word is
// looked up in the look state, and the result word is registered once the output
// slot is free; no new command is taken before that. Init walks all T table entries
// and setup the first S, T = min(SPARSE_DEPTH, 2048) and S the size in use; both
// make one forward table access per cycle. After reset a clearing pass marks all
// entries unmapped and takes no command, while register writes are taken as always.
`timescale 1ns / 1ps

`include "sparse_compact_index_map_macros.svh"

module sparse_compact_index_map #(
    parameter int SPARSE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scim_cmd_if.sink    i_cmd,
    scim_res_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import scim_pkg::*;

    localparam int TabDepth = (SPARSE_DEPTH < 2048) ? SPARSE_DEPTH : 2048;
    localparam int AW       = $clog2(TabDepth);
    localparam int CW       = $clog2(TabDepth + 1);
    localparam int CapW     = SIZE_W + 1;
    localparam logic [CapW-1:0] DepthCap = CapW'(TabDepth);
    localparam logic [CW-1:0]   WalkLast = CW'(TabDepth - 1);
    localparam logic            RegSparseSize = 1'b0;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_INIT  = 3'd2;
    localparam logic [2:0] S_SETUP = 3'd3;
    localparam logic [2:0] S_LOOK  = 3'd4;

    logic [2:0]              r_state, n_state;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [CW-1:0]           r_n, n_n;
    logic                    r_sv, n_sv;
    logic [AW-1:0]           r_sa, n_sa;
    logic [SIZE_W-1:0]       r_total, n_total;
    logic signed [RES_W-1:0] r_last, n_last;
    logic [SIZE_W-1:0]       r_miss, n_miss;
    logic [SIZE_W-1:0]       r_size;
    logic                    r_ovalid, n_ovalid;

    t_op                     r_op;
    logic [IDX_W-1:0]        r_idx;
    logic                    r_mapped;
    logic                    r_first;

    logic signed [RES_W-1:0] r_res, n_res;
    logic                    r_found, n_found;
    logic                    r_emit, n_emit;
    logic [SIZE_W-1:0]       r_omiss, n_omiss;
    logic [SIZE_W-1:0]       r_ocount, n_ocount;

    logic                    w_accept;
    logic [SIZE_W-1:0]       w_used;
    logic                    w_cnt_in;
    logic                    w_slot;
    logic                    w_setup_hit;

    logic                    w_fwd_we;
    logic [AW-1:0]           w_fwd_waddr;
    logic [AW:0]             w_fwd_wdata;
    logic                    w_fwd_re;
    logic [AW-1:0]           w_fwd_raddr;
    logic [AW:0]             w_fwd_rdata;
    logic [AW-1:0]           w_rev_rdata;

    logic signed [RES_W-1:0] w_lg;
    logic [SIZE_W-1:0]       w_mc;
    logic                    w_fhit;
    logic [RES_W-1:0]        w_fval;
    logic                    w_rhit;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_accept    = i_cmd.valid && (r_state == S_IDLE);
    assign w_used      = ({1'b0, r_size} < DepthCap) ? r_size : SIZE_W'(TabDepth);
    assign w_cnt_in    = (CapW'(r_cnt) < {1'b0, w_used});
    assign w_slot      = !r_ovalid || o_res.ready;
    assign w_setup_hit = (r_state == S_SETUP) && r_sv && w_fwd_rdata[AW];

    assign pready = 1'b1;
    assign prdata = (paddr[2] == RegSparseSize) ? 32'(r_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == RegSparseSize)) begin
            r_size <= pwdata[SIZE_W-1:0];
        end
    end

    always_comb begin
        w_fwd_we    = 1'b0;
        w_fwd_waddr = r_cnt[AW-1:0];
        w_fwd_wdata = '0;
        w_fwd_re    = 1'b0;
        w_fwd_raddr = AW'(i_cmd.index);
        case (r_state)
            S_CLEAR: begin
                w_fwd_we = 1'b1;
            end
            S_INIT: begin
                w_fwd_we = 1'b1;
                if (r_mapped && w_cnt_in) begin
                    w_fwd_wdata = {1'b1, r_cnt[AW-1:0]};
                end
            end
            S_IDLE: begin
                w_fwd_re = w_accept;
                if (w_accept && (i_cmd.operation == OP_SET) &&
                    ({1'b0, i_cmd.index} < w_used)) begin
                    w_fwd_we    = 1'b1;
                    w_fwd_waddr = AW'(i_cmd.index);
                    w_fwd_wdata = {i_cmd.mapped, {AW{1'b0}}};
                end
            end
            S_SETUP: begin
                w_fwd_raddr = r_cnt[AW-1:0];
                w_fwd_re    = w_cnt_in;
                w_fwd_we    = w_setup_hit;
                w_fwd_waddr = r_sa;
                w_fwd_wdata = {1'b1, r_n[AW-1:0]};
            end
            default: begin
            end
        endcase
    end

    scim_ram #(
        .WIDTH (AW + 1),
        .DEPTH (TabDepth)
    ) u_fwd_ram (
        .i_clk   (i_clk),
        .i_we    (w_fwd_we),
        .i_waddr (w_fwd_waddr),
        .i_wdata (w_fwd_wdata),
        .i_re    (w_fwd_re),
        .i_raddr (w_fwd_raddr),
        .o_rdata (w_fwd_rdata)
    );

    scim_ram #(
        .WIDTH (AW),
        .DEPTH (TabDepth)
    ) u_rev_ram (
        .i_clk   (i_clk),
        .i_we    (w_setup_hit),
        .i_waddr (r_n[AW-1:0]),
        .i_wdata (r_sa),
        .i_re    (w_accept),
        .i_raddr (AW'(i_cmd.index)),
        .o_rdata (w_rev_rdata)
    );

    assign w_lg   = r_first ? '1 : r_last;
    assign w_mc   = r_first ? '0 : r_miss;
    assign w_fhit = ({1'b0, r_idx} < w_used) && w_fwd_rdata[AW];
    assign w_fval = RES_W'(w_fwd_rdata[AW-1:0]);
    assign w_rhit = ({1'b0, r_idx} < r_total);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_n      = r_n;
        n_sv     = r_sv;
        n_sa     = r_sa;
        n_total  = r_total;
        n_last   = r_last;
        n_miss   = r_miss;
        n_ovalid = r_ovalid && !o_res.ready;
        n_res    = r_res;
        n_found  = r_found;
        n_emit   = r_emit;
        n_omiss  = r_omiss;
        n_ocount = r_ocount;
        case (r_state)
            S_CLEAR, S_INIT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == WalkLast) begin
                    n_cnt   = '0;
                    n_state = (r_state == S_CLEAR) ? S_IDLE : S_LOOK;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (i_cmd.operation)
                        OP_INIT: begin
                            n_state = S_INIT;
                            n_cnt   = '0;
                        end
                        OP_SETUP: begin
                            n_state = S_SETUP;
                            n_cnt   = '0;
                            n_n     = '0;
                            n_sv    = 1'b0;
                        end
                        default: begin
                            n_state = S_LOOK;
                        end
                    endcase
                end
            end
            S_SETUP: begin
                if (w_setup_hit) begin
                    n_n = r_n + 1'b1;
                end
                if (w_cnt_in) begin
                    n_sv  = 1'b1;
                    n_sa  = r_cnt[AW-1:0];
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    n_sv = 1'b0;
                    if (!r_sv) begin
                        n_total = SIZE_W'(r_n);
                        n_cnt   = '0;
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                if (w_slot) begin
                    n_state  = S_IDLE;
                    n_ovalid = 1'b1;
                    n_res    = '1;
                    n_found  = 1'b0;
                    n_emit   = 1'b0;
                    n_omiss  = r_miss;
                    n_ocount = r_total;
                    case (r_op)
                        OP_MAP: begin
                            n_last  = w_lg;
                            n_miss  = w_mc;
                            n_omiss = w_mc;
                            if (w_fhit) begin
                                n_res   = w_fval;
                                n_found = 1'b1;
                                if (w_fval != w_lg) begin
                                    n_emit = 1'b1;
                                    n_last = w_fval;
                                end
                            end else if (w_mc < MISS_LIMIT) begin
                                n_miss  = w_mc + 1'b1;
                                n_omiss = w_mc + 1'b1;
                            end
                        end
                        OP_REV: begin
                            if (w_rhit) begin
                                n_res   = RES_W'(w_rev_rdata);
                                n_found = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_n      <= '0;
            r_sv     <= 1'b0;
            r_total  <= '0;
            r_last   <= '1;
            r_miss   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_n      <= n_n;
            r_sv     <= n_sv;
            r_total  <= n_total;
            r_last   <= n_last;
            r_miss   <= n_miss;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sa     <= n_sa;
        r_res    <= n_res;
        r_found  <= n_found;
        r_emit   <= n_emit;
        r_omiss  <= n_omiss;
        r_ocount <= n_ocount;
        if (w_accept) begin
            r_op     <= i_cmd.operation;
            r_idx    <= i_cmd.index;
            r_mapped <= i_cmd.mapped;
            r_first  <= i_cmd.first_of_list;
        end
    end

    assign o_res.valid         = r_ovalid;
    assign o_res.result_index  = r_res;
    assign o_res.found         = r_found;
    assign o_res.emitted       = r_emit;
    assign o_res.missed_count  = r_omiss;
    assign o_res.compact_count = r_ocount;

    `SCIM_ASSERT_IMPL(a_emit_needs_found, i_clk, i_rst_n, o_res.valid && o_res.emitted, o_res.found)
    `SCIM_ASSERT_IMPL(a_miss_saturates, i_clk, i_rst_n, o_res.valid, o_res.missed_count <= MISS_LIMIT)
    `SCIM_ASSERT_NEXT(a_short_op_looks_up, i_clk, i_rst_n, w_accept && (i_cmd.operation != OP_INIT) && (i_cmd.operation != OP_SETUP), r_state == S_LOOK)
    `SCIM_ASSERT_IMPL(a_setup_dense, i_clk, i_rst_n, w_setup_hit, r_n <= CW'(r_sa))

endmodule
